>>> rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants
// Word formats, sequencer states, register indexes and serial multiplier
// geometry for the decaying sine tone generator.
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int PHASE_BITS_DEF       = 24;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int SAMPLE_W = 16;
  localparam int ROM_W    = 15;
  localparam int ENV_W    = 24;
  localparam int GAIN_W   = 17;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [ENV_W-1:0]  ENV_ONE   = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SAMPLES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_GAIN_STEP = 2'd2;

  localparam logic [15:0] VOLUME_GAIN_RST    = 16'd9830;
  localparam logic [11:0] RAMP_SAMPLES_RST   = 12'd110;
  localparam logic [15:0] RAMP_GAIN_STEP_RST = 16'd596;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 24;
  localparam int MUL_DIG = 4;
  localparam int MUL_ND  = MUL_B_W / MUL_DIG;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic [MUL_A_W-1:0] dst_mul_a_t;
  typedef logic [MUL_B_W-1:0] dst_mul_b_t;
  typedef logic [MUL_P_W-1:0] dst_mul_p_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] phase_step;
    logic [15:0] note_length;
    logic [23:0] decay_factor;
  } dst_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_note;
    logic                       playing;
  } dst_out_t;

  typedef struct packed {
    logic       start;
    dst_mul_a_t a;
    dst_mul_b_t b;
  } dst_mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dst_mul_sts_t;

  typedef struct packed {
    logic             neg;
    logic [ROM_W-1:0] mag;
  } dst_rom_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROM,
    ST_GIN,
    ST_FIN,
    ST_GOUT,
    ST_FOUT,
    ST_MROM,
    ST_MVOL,
    ST_DEC,
    ST_EMIT
  } dst_state_t;

endpackage

>>> rtl/dst_serial_mul.sv
// ----------------------------------------------------------------------------
// dst_serial_mul: digit-serial unsigned multiplier
// Consumes the multiplier four bits per cycle, low digit first; the low
// product digits shift into the multiplier register as it empties.
// ----------------------------------------------------------------------------
module dst_serial_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dst_pkg::dst_mul_req_t req,
  output dst_pkg::dst_mul_sts_t sts,
  output dst_pkg::dst_mul_p_t   product
);

  localparam int SUM_W = dst_pkg::MUL_A_W + dst_pkg::MUL_DIG;
  localparam int CNT_W = $clog2(dst_pkg::MUL_ND);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dst_pkg::MUL_ND - 1);

  dst_pkg::dst_mul_a_t a_r;
  dst_pkg::dst_mul_a_t acc_r;
  dst_pkg::dst_mul_b_t b_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [SUM_W-1:0]    part;
  logic [SUM_W-1:0]    sum;

  assign part = SUM_W'(a_r) * SUM_W'(b_r[dst_pkg::MUL_DIG-1:0]);
  assign sum  = SUM_W'(acc_r) + part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      acc_r <= sum[SUM_W-1:dst_pkg::MUL_DIG];
      b_r   <= {sum[dst_pkg::MUL_DIG-1:0], b_r[dst_pkg::MUL_B_W-1:dst_pkg::MUL_DIG]};
    end else if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = {acc_r, b_r};

endmodule

>>> rtl/dst_sine_rom.sv
// ----------------------------------------------------------------------------
// dst_sine_rom: quarter-wave sine lookup
// Maps the phase to a quadrant and a table index, mirrors odd quadrants and
// reads the Q0.15 magnitude; two register stages from phase to data.
// ----------------------------------------------------------------------------
module dst_sine_rom #(
  parameter int PHASE_BITS       = dst_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dst_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic [PHASE_BITS-1:0] phase,
  output dst_pkg::dst_rom_t     rom_word
);

  localparam int QS = PHASE_BITS - 2;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [dst_pkg::ROM_W-1:0] sine_q15(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 6; i++) begin
      term = (term * x2) >> 30;
      unique case (i)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    r = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return dst_pkg::ROM_W'(r);
  endfunction

  logic [dst_pkg::ROM_W-1:0] tab [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    assign tab[k] = sine_q15(k);
  end

  logic [QS+IW-1:0] scaled;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_r;
  logic [1:0]       quad_r;

  assign scaled = (QS+IW)'(phase[QS-1:0]) * (QS+IW)'(SINE_TABLE_DEPTH);
  assign idx    = scaled[QS +: IW];

  always_ff @(posedge clk) begin
    quad_r       <= phase[PHASE_BITS-1:QS];
    idx_r        <= phase[QS] ? IW'(SINE_TABLE_DEPTH) - idx : idx;
    rom_word.neg <= quad_r[1];
    rom_word.mag <= tab[idx_r];
  end

endmodule

>>> rtl/decaying_sine_tone_generator.sv
// ----------------------------------------------------------------------------
// decaying_sine_tone_generator: DDS bell tone with decay and fades
// A start word loads a note; each tick word yields one sample word.
// A start word leaves the input ready. An idle tick goes straight to the
// emit state; an active tick makes 3, 5 or 7 passes of the shared 4-bit
// digit-serial multiplier. The input is held off until the word is emitted.
// Synchronous active-low reset: idle, registers at defaults, no sweep.
// ----------------------------------------------------------------------------
module decaying_sine_tone_generator #(
  parameter int PHASE_BITS       = dst_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dst_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dst_pkg::dst_in_t                 in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dst_pkg::dst_out_t                out_word,
  input  logic                             cfg_we,
  input  logic [dst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dst_pkg::CFG_W-1:0]        cfg_wdata
);

  dst_pkg::dst_state_t state_r, state_nxt;

  logic [15:0]                volume_gain_r;
  logic [11:0]                ramp_samples_r;
  logic [15:0]                ramp_gain_step_r;

  logic [PHASE_BITS-1:0]      phase_r;
  logic [PHASE_BITS-1:0]      step_r;
  logic [15:0]                n_r;
  logic [15:0]                len_r;
  logic [dst_pkg::ENV_W-1:0]  envelope_r;
  logic [dst_pkg::ENV_W-1:0]  decay_r;
  logic                       active_r;

  logic [dst_pkg::ENV_W-1:0]  env_w_r;
  logic [dst_pkg::GAIN_W-1:0] gain_r;
  logic [38:0]                p1_r;
  logic [15:0]                left_r;
  logic                       fin_r;
  logic                       fout_r;
  logic                       last_r;
  logic                       play_r;
  logic [15:0]                samp_r;
  logic                       out_valid_r;
  dst_pkg::dst_out_t          out_word_r;

  dst_pkg::dst_mul_req_t      mul_req;
  dst_pkg::dst_mul_sts_t      mul_sts;
  dst_pkg::dst_mul_p_t        mul_p;
  dst_pkg::dst_rom_t          rom_word;
  logic                       is_mul;
  logic                       accept;
  logic                       slot_free;
  logic [15:0]                left_now;
  logic [15:0]                ramp_ext;
  logic [15:0]                mag;
  logic [dst_pkg::GAIN_W-1:0] gain_sat;

  dst_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .sts     (mul_sts),
    .product (mul_p)
  );

  dst_sine_rom #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk      (clk),
    .phase    (phase_r),
    .rom_word (rom_word)
  );

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign ramp_ext  = {4'b0, ramp_samples_r};
  assign left_now  = len_r - n_r;
  assign mag       = mul_p[55:40];
  assign gain_sat  = (mul_p[31:0] > 32'(dst_pkg::GAIN_ONE)) ? dst_pkg::GAIN_ONE
                                                          : mul_p[16:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dst_pkg::ST_IDLE: begin
        if (accept && in_word.kind == dst_pkg::KIND_TICK) begin
          state_nxt = active_r ? dst_pkg::ST_ROM : dst_pkg::ST_EMIT;
        end
      end
      dst_pkg::ST_ROM: begin
        priority if (fin_r) begin
          state_nxt = dst_pkg::ST_GIN;
        end else if (fout_r) begin
          state_nxt = dst_pkg::ST_GOUT;
        end else begin
          state_nxt = dst_pkg::ST_MROM;
        end
      end
      dst_pkg::ST_GIN:  if (mul_sts.done) state_nxt = dst_pkg::ST_FIN;
      dst_pkg::ST_FIN: begin
        if (mul_sts.done) begin
          state_nxt = fout_r ? dst_pkg::ST_GOUT : dst_pkg::ST_MROM;
        end
      end
      dst_pkg::ST_GOUT: if (mul_sts.done) state_nxt = dst_pkg::ST_FOUT;
      dst_pkg::ST_FOUT: if (mul_sts.done) state_nxt = dst_pkg::ST_MROM;
      dst_pkg::ST_MROM: if (mul_sts.done) state_nxt = dst_pkg::ST_MVOL;
      dst_pkg::ST_MVOL: if (mul_sts.done) state_nxt = dst_pkg::ST_DEC;
      dst_pkg::ST_DEC:  if (mul_sts.done) state_nxt = dst_pkg::ST_EMIT;
      dst_pkg::ST_EMIT: if (slot_free) state_nxt = dst_pkg::ST_IDLE;
      default:          state_nxt = dst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    is_mul    = 1'b1;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state_r)
      dst_pkg::ST_GIN: begin
        mul_req.a = dst_pkg::dst_mul_a_t'(ramp_gain_step_r);
        mul_req.b = dst_pkg::dst_mul_b_t'(n_r);
      end
      dst_pkg::ST_GOUT: begin
        mul_req.a = dst_pkg::dst_mul_a_t'(ramp_gain_step_r);
        mul_req.b = dst_pkg::dst_mul_b_t'(left_r);
      end
      dst_pkg::ST_FIN, dst_pkg::ST_FOUT: begin
        mul_req.a = dst_pkg::dst_mul_a_t'(env_w_r);
        mul_req.b = dst_pkg::dst_mul_b_t'(gain_r);
      end
      dst_pkg::ST_MROM: begin
        mul_req.a = dst_pkg::dst_mul_a_t'(env_w_r);
        mul_req.b = dst_pkg::dst_mul_b_t'(rom_word.mag);
      end
      dst_pkg::ST_MVOL: begin
        mul_req.a = dst_pkg::dst_mul_a_t'(p1_r);
        mul_req.b = dst_pkg::dst_mul_b_t'(volume_gain_r);
      end
      dst_pkg::ST_DEC: begin
        mul_req.a = dst_pkg::dst_mul_a_t'(envelope_r);
        mul_req.b = dst_pkg::dst_mul_b_t'(decay_r);
      end
      default: is_mul = 1'b0;
    endcase
    mul_req.start = is_mul && !mul_sts.busy && !mul_sts.done;
    in_ready      = (state_r == dst_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= dst_pkg::ST_IDLE;
      volume_gain_r    <= dst_pkg::VOLUME_GAIN_RST;
      ramp_samples_r   <= dst_pkg::RAMP_SAMPLES_RST;
      ramp_gain_step_r <= dst_pkg::RAMP_GAIN_STEP_RST;
      phase_r          <= '0;
      step_r           <= '0;
      n_r              <= '0;
      len_r            <= '0;
      envelope_r       <= dst_pkg::ENV_ONE;
      decay_r          <= '0;
      active_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dst_pkg::CFG_VOLUME_GAIN:    volume_gain_r    <= cfg_wdata;
          dst_pkg::CFG_RAMP_SAMPLES:   ramp_samples_r   <= cfg_wdata[11:0];
          dst_pkg::CFG_RAMP_GAIN_STEP: ramp_gain_step_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && in_word.kind == dst_pkg::KIND_START) begin
        step_r     <= PHASE_BITS'(in_word.phase_step);
        len_r      <= in_word.note_length;
        decay_r    <= in_word.decay_factor;
        phase_r    <= '0;
        n_r        <= '0;
        envelope_r <= dst_pkg::ENV_ONE;
        active_r   <= (in_word.note_length != 16'd0);
      end
      if (state_r == dst_pkg::ST_DEC && mul_sts.done) begin
        envelope_r <= mul_p[47:24];
        phase_r    <= phase_r + step_r;
        n_r        <= n_r + 16'd1;
        if (last_r) begin
          active_r <= 1'b0;
        end
      end
      if (state_r == dst_pkg::ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_word.kind == dst_pkg::KIND_TICK) begin
      env_w_r <= envelope_r;
      left_r  <= left_now;
      fin_r   <= (n_r < ramp_ext);
      fout_r  <= (left_now < ramp_ext);
      last_r  <= active_r && ((17'(n_r) + 17'd1) == 17'(len_r));
      play_r  <= active_r;
      samp_r  <= '0;
    end
    if (mul_sts.done) begin
      unique case (state_r)
        dst_pkg::ST_GIN, dst_pkg::ST_GOUT: gain_r  <= gain_sat;
        dst_pkg::ST_FIN, dst_pkg::ST_FOUT: env_w_r <= mul_p[39:16];
        dst_pkg::ST_MROM:                  p1_r    <= mul_p[38:0];
        dst_pkg::ST_MVOL: samp_r <= rom_word.neg ? 16'd0 - mag : mag;
        default: ;
      endcase
    end
    if (state_r == dst_pkg::ST_EMIT && slot_free) begin
      out_word_r.sample       <= samp_r;
      out_word_r.last_of_note <= last_r;
      out_word_r.playing      <= play_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/dst_checker.sv
// ----------------------------------------------------------------------------
// dst_checker: port-level checks for the tone generator
// Watches the word channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module dst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input dst_pkg::dst_in_t  in_word,
  input logic              out_valid,
  input logic              out_ready,
  input dst_pkg::dst_out_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.playing |-> out_word.sample == 16'sd0 && !out_word.last_of_note)
    else $error("idle result word is not silent");

  a_start_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_word.kind == dst_pkg::KIND_START |=> in_ready)
    else $error("start word did not complete in one cycle");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_word.kind == dst_pkg::KIND_TICK |=> !in_ready)
    else $error("tick word did not hold off the input");

endmodule

bind decaying_sine_tone_generator dst_checker u_dst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
